// ----- rtl/deq_pkg.sv -----
// shared types and constants for the double-ended queue
package deq_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed widths of the request and result fields
	localparam int OP_W = 3;
	localparam int VALUE_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 7;

	// cells per group in the tail select
	localparam int TAIL_GROUP = 8;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CLEAR      = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// one-cycle commands broadcast to every cell
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic clear;
	} cell_ctrl_t;

endpackage

// ----- rtl/deq_cmd_if.sv -----
// request channel: operation and push data
interface deq_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [deq_pkg::OP_W-1:0]     op;
	logic [deq_pkg::VALUE_W-1:0]  push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink (input valid, input op, input push_value, output ready);
endinterface

// ----- rtl/deq_rsp_if.sv -----
// result channel: popped value, status and element count
interface deq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [deq_pkg::VALUE_W-1:0]   pop_value;
	logic [deq_pkg::STATUS_W-1:0]  status;
	logic [deq_pkg::COUNT_W-1:0]   count;

	modport source (output valid, output pop_value, output status, output count, input ready);
	modport sink (input valid, input pop_value, input status, input count, output ready);
endinterface

// ----- rtl/deq_cell.sv -----
// one queue slot: holds an entry and shifts it to either neighbor
module deq_cell #(
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  deq_pkg::cell_ctrl_t     ctrl,
	input  logic [DATA_WIDTH-1:0]   push_data,
	input  logic                    left_valid,
	input  logic [DATA_WIDTH-1:0]   left_data,
	input  logic                    right_valid,
	input  logic [DATA_WIDTH-1:0]   right_data,
	output logic                    valid,
	output logic [DATA_WIDTH-1:0]   data,
	output logic                    is_last
);
	import deq_pkg::*;

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  valid_d;
	logic [DATA_WIDTH-1:0] data_d;

	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		if (ctrl.clear) begin
			valid_d = 1'b0;
		end else if (ctrl.push_front) begin
			valid_d = left_valid;
			data_d  = left_data;
		end else if (ctrl.pop_front) begin
			valid_d = right_valid;
			data_d  = right_data;
		end else if (ctrl.push_back) begin
			// first empty slot takes the new entry
			if (!valid_q && left_valid) begin
				valid_d = 1'b1;
				data_d  = push_data;
			end
		end else if (ctrl.pop_back) begin
			if (valid_q && !right_valid) begin
				valid_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign valid   = valid_q;
	assign data    = data_q;
	assign is_last = valid_q && !right_valid;
endmodule

// ----- rtl/deq_tail_sel.sv -----
// picks the back entry: registered group or, then a final or across groups
module deq_tail_sel #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic [DEPTH-1:0]                    last,
	input  logic [DEPTH-1:0][DATA_WIDTH-1:0]    data,
	output logic [DATA_WIDTH-1:0]               tail_data
);
	import deq_pkg::*;

	localparam int NGROUP = (DEPTH + TAIL_GROUP - 1) / TAIL_GROUP;

	logic [NGROUP-1:0][DATA_WIDTH-1:0] grp_q;

	for (genvar g = 0; g < NGROUP; g++) begin : g_grp
		logic [DATA_WIDTH-1:0] grp_or;

		always_comb begin
			grp_or = '0;
			for (int k = 0; k < TAIL_GROUP; k++) begin
				if (g * TAIL_GROUP + k < DEPTH) begin
					if (last[g * TAIL_GROUP + k]) begin
						grp_or = grp_or | data[g * TAIL_GROUP + k];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			grp_q[g] <= grp_or;
		end
	end

	// only one cell is last, so an or picks it
	always_comb begin
		tail_data = '0;
		for (int g = 0; g < NGROUP; g++) begin
			tail_data = tail_data | grp_q[g];
		end
	end
endmodule

// ----- rtl/double_ended_queue.sv -----
// bounded double-ended queue built as a row of shifting cells
// flow: a request is registered, run in the exec state, and its result registered;
//   exec holds while a result waits. A new request is taken only when idle, so the
//   tail select register takes in the updated cells before the next back pop
// reset: the queue comes up empty; cell contents are not cleared
module double_ended_queue #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	deq_cmd_if.sink   cmd,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IN_W   = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam int CEXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	state_t                state_q, state_d;
	logic [OP_W-1:0]       op_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [CNT_W-1:0]      count_q, count_d;
	logic                  rsp_valid_q;
	logic [VALUE_W-1:0]    pop_value_q;
	status_t               status_q;
	logic [COUNT_W-1:0]    rsp_count_q;

	cell_ctrl_t            ctrl;
	logic                  accept;
	logic                  go;
	logic                  full;
	logic                  empty;
	logic [IN_W-1:0]       push_ext;
	logic [DATA_WIDTH-1:0] popped;
	logic [IN_W-1:0]       popped_ext;
	status_t               status_d;
	logic [CEXT_W-1:0]     count_ext;
	logic [DATA_WIDTH-1:0] tail_data;

	logic [DEPTH-1:0]                 cell_valid;
	logic [DEPTH-1:0]                 cell_last;
	logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign push_ext = IN_W'(cmd.push_value);
	assign accept   = cmd.valid && cmd.ready;
	assign go       = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		ctrl      = '0;
		count_d   = count_q;
		status_d  = STAT_DONE;
		popped    = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (go) begin
					state_d = ST_IDLE;
					case (op_q)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								ctrl.push_front = (op_q == OP_PUSH_FRONT);
								ctrl.push_back  = (op_q == OP_PUSH_BACK);
								count_d         = count_q + 1'b1;
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (empty) begin
								status_d = STAT_EMPTY;
							end else begin
								ctrl.pop_front = (op_q == OP_POP_FRONT);
								ctrl.pop_back  = (op_q == OP_POP_BACK);
								popped  = (op_q == OP_POP_FRONT) ? cell_data[0] : tail_data;
								count_d = count_q - 1'b1;
							end
						end
						OP_CLEAR: begin
							ctrl.clear = 1'b1;
							count_d    = '0;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign popped_ext = IN_W'(popped);
	assign count_ext  = CEXT_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= cmd.op;
			value_q <= push_ext[DATA_WIDTH-1:0];
		end
		if (go) begin
			pop_value_q <= popped_ext[VALUE_W-1:0];
			status_q    <= status_d;
			rsp_count_q <= count_ext[COUNT_W-1:0];
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pop_value = pop_value_q;
	assign rsp.status    = status_q;
	assign rsp.count     = rsp_count_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  lv, rv;
		logic [DATA_WIDTH-1:0] ld, rd;

		// the front cell sees the new entry on its left, the last cell an empty slot
		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign ld = value_q;
		end else begin : g_mid_l
			assign lv = cell_valid[i-1];
			assign ld = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_mid_r
			assign rv = cell_valid[i+1];
			assign rd = cell_data[i+1];
		end

		deq_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.push_data   (value_q),
			.left_valid  (lv),
			.left_data   (ld),
			.right_valid (rv),
			.right_data  (rd),
			.valid       (cell_valid[i]),
			.data        (cell_data[i]),
			.is_last     (cell_last[i])
		);
	end

	deq_tail_sel #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_tail_sel (
		.clk       (clk),
		.last      (cell_last),
		.data      (cell_data),
		.tail_data (tail_data)
	);
endmodule

// ----- verif/tb_top.sv -----
// testbench for the double-ended queue: directed, fill/drain, backpressure and random requests
`timescale 1ns / 1ps

module tb_top;
	import deq_pkg::*;

	localparam int QDEPTH = DEPTH_DEF;
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_W'(OP_CLEAR + 1);
	localparam logic [OP_W-1:0] OP_SPARE_LAST = '1;

	typedef struct packed {
		logic [VALUE_W-1:0] pop_value;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} deq_result_t;

	logic clk = 1'b0;
	logic arst_n;

	deq_cmd_if cmd_ch();
	deq_rsp_if rsp_ch();

	double_ended_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	// mirror of the queue contents
	logic [VALUE_W-1:0] mirror_store [QDEPTH];
	int                 mirror_front;
	int                 mirror_count;

	deq_result_t pending_results[$];
	int          error_count;
	bit          idle_enable;
	int          hold_off_request;

	function automatic int draw_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic deq_result_t apply_request(logic [OP_W-1:0] op,
			logic [VALUE_W-1:0] value);
		deq_result_t res;
		int          slot;
		res = '{pop_value: '0, status: STAT_DONE, count: '0};
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (mirror_count >= QDEPTH) begin
					res.status = STAT_FULL;
				end else begin
					if (op == OP_PUSH_FRONT) begin
						slot = (mirror_front + QDEPTH - 1) % QDEPTH;
						mirror_front = slot;
					end else begin
						slot = (mirror_front + mirror_count) % QDEPTH;
					end
					mirror_store[slot] = value;
					mirror_count++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (mirror_count == 0) begin
					res.status = STAT_EMPTY;
				end else if (op == OP_POP_FRONT) begin
					res.pop_value = mirror_store[mirror_front];
					mirror_front = (mirror_front + 1) % QDEPTH;
					mirror_count--;
				end else begin
					slot = (mirror_front + mirror_count - 1) % QDEPTH;
					res.pop_value = mirror_store[slot];
					mirror_count--;
				end
			end
			OP_CLEAR: begin
				mirror_front = 0;
				mirror_count = 0;
			end
			default: ;
		endcase
		res.count = COUNT_W'(mirror_count);
		return res;
	endfunction

	// weights in percent; the rest are pops
	function automatic logic [OP_W-1:0] pick_op(int push_pct, int clear_pct, int spare_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		if (r < push_pct + clear_pct)
			return OP_CLEAR;
		if (r < push_pct + clear_pct + spare_pct)
			return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	// valid is left high after a request so back-to-back requests need no toggle
	task automatic issue_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
		int gap;
		gap = (idle_enable && $urandom_range(0, 99) < 40) ? draw_gap() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.op         <= op;
		cmd_ch.push_value <= value;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_results.push_back(apply_request(op, value));
	endtask

	task automatic drain_pause();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		issue_request(OP_POP_FRONT, 32'h1234_5678);
		issue_request(OP_POP_BACK, 32'h8765_4321);
		issue_request(OP_PUSH_FRONT, 32'h0000_0000);
		issue_request(OP_PUSH_BACK, 32'hFFFF_FFFF);
		issue_request(OP_PUSH_FRONT, 32'hA5A5_A5A5);
		issue_request(OP_PUSH_BACK, 32'h5A5A_5A5A);
		for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
			issue_request(OP_W'(c), $urandom());
		issue_request(OP_POP_FRONT, 32'h0);
		issue_request(OP_POP_BACK, 32'h0);
		issue_request(OP_POP_BACK, 32'h0);
		issue_request(OP_POP_FRONT, 32'h0);
		issue_request(OP_POP_FRONT, 32'h0);
		issue_request(OP_PUSH_BACK, 32'h0000_0001);
		issue_request(OP_PUSH_BACK, 32'h8000_0000);
		// clear while holding data, then nothing must come back
		issue_request(OP_CLEAR, $urandom());
		issue_request(OP_POP_BACK, 32'h0);
		issue_request(OP_PUSH_FRONT, 32'hDEAD_BEEF);
		issue_request(OP_POP_BACK, 32'h0);
		issue_request(OP_CLEAR, 32'h0);
		drain_pause();
	endtask

	task automatic test_fill_and_drain();
		for (int round = 0; round < 3; round++) begin
			idle_enable = (round != 1);
			while (mirror_count < QDEPTH)
				issue_request(pick_op(80, 0, 2), $urandom());
			// mostly pushes against a full queue, with some pops and spare codes
			repeat (6) issue_request(pick_op(80, 0, 2), $urandom());
			while (mirror_count != 0)
				issue_request(pick_op(20, 0, 2), $urandom());
			repeat (6) issue_request(pick_op(20, 0, 2), $urandom());
		end
		idle_enable = 1'b1;
	endtask

	task automatic test_backpressure();
		hold_off_request = 160;
		idle_enable = 1'b0;
		repeat (60) issue_request(pick_op(55, 0, 0), $urandom());
		idle_enable = 1'b1;
		drain_pause();
	endtask

	task automatic test_random_mix();
		repeat (150) issue_request(pick_op(50, 3, 3), $urandom());
		drain_pause();
		repeat (150) issue_request(pick_op(50, 3, 3), $urandom());
	endtask

	// result side: random stalls plus the long hold-off
	initial begin : result_checker
		int          stall_left;
		int          hold_left;
		deq_result_t exp;
		stall_left = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("result with no request waiting");
					error_count++;
				end else begin
					exp = pending_results.pop_front();
					if (rsp_ch.pop_value !== exp.pop_value) begin
						$error("pop_value: expected %h, got %h", exp.pop_value, rsp_ch.pop_value);
						error_count++;
					end
					if (rsp_ch.status !== exp.status) begin
						$error("status: expected %0d, got %0d", exp.status, rsp_ch.status);
						error_count++;
					end
					if (rsp_ch.count !== exp.count) begin
						$error("count: expected %0d, got %0d", exp.count, rsp_ch.count);
						error_count++;
					end
				end
			end
			if (hold_off_request > 0) begin
				hold_left = hold_off_request;
				hold_off_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (idle_enable && $urandom_range(0, 3) == 0)
					stall_left = draw_gap();
			end
		end
	end

	initial begin
		error_count = 0;
		idle_enable = 1'b1;
		hold_off_request = 0;
		mirror_front = 0;
		mirror_count = 0;
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.op <= OP_PUSH_FRONT;
		cmd_ch.push_value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_backpressure();
		test_random_mix();

		drain_pause();
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/deq_pkg.sv
rtl/deq_cmd_if.sv
rtl/deq_rsp_if.sv
rtl/deq_cell.sv
rtl/deq_tail_sel.sv
rtl/double_ended_queue.sv
verif/tb_top.sv
